/* src/x86cc_pkg.sv */
// ----------------------------------------------------------------------------
// x86cc_pkg
// Shared types, constants and helpers for the x86 call chunk classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package x86cc_pkg;

  // Longest chunk that the counters track before they saturate.
  localparam int MAX_CHUNK = 16384;

  // Counter width: enough to hold MAX_CHUNK itself.
  localparam int CNT_W = $clog2(MAX_CHUNK + 1);

  // Reported call count width and its ceiling.
  localparam int CALL_CNT_W    = 15;
  localparam int COUNT_OUT_MAX = 32767;

  // Width that holds both a counter and the reported ceiling.
  localparam int CMP_W = (CNT_W > CALL_CNT_W) ? CNT_W : CALL_CNT_W;

  // Byte window and the opcode bytes that it is checked against.
  localparam int         WIN_DEPTH   = 5;
  localparam logic [7:0] CALL_OPCODE = 8'hE8;
  localparam logic [7:0] BYTE_ONES   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO   = 8'h00;

  // Verdict ratios in integer form: calls/len >= 1/500, hits/calls >= 1/5,
  // exe/calls >= 1/100.
  localparam int LEN_RATIO  = 500;
  localparam int HIT_RATIO  = 5;
  localparam int EXE_RATIO  = 100;

  typedef logic [CNT_W-1:0] cnt_t;

  // Snapshot of the chunk counters taken at the chunk's last byte.
  typedef struct packed {
    cnt_t len;
    cnt_t calls;
    cnt_t exe;
    cnt_t obj;
  } counts_t;

  typedef struct packed {
    logic                  is_exe;
    logic [CALL_CNT_W-1:0] call_count;
  } verdict_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    if (v >= CNT_W'(MAX_CHUNK)) begin
      r = CNT_W'(MAX_CHUNK);
    end else begin
      r = v + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/x86cc_in_if.sv */
// ----------------------------------------------------------------------------
// x86cc_in_if
// Byte channel into the classifier: one chunk byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface x86cc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

/* src/x86cc_out_if.sv */
// ----------------------------------------------------------------------------
// x86cc_out_if
// Verdict channel out of the classifier: one verdict per chunk.
// ----------------------------------------------------------------------------
`default_nettype none

interface x86cc_out_if;
  logic        valid;
  logic        ready;
  logic        is_exe;
  logic [14:0] call_count;

  modport source (output valid, output is_exe, output call_count, input ready);
  modport sink   (input valid, input is_exe, input call_count, output ready);
endinterface

`default_nettype wire

/* src/x86cc_verdict.sv */
// ----------------------------------------------------------------------------
// x86cc_verdict
// Turns a chunk's final counter snapshot into the code/data verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module x86cc_verdict (
  input  x86cc_pkg::counts_t  counts,
  output x86cc_pkg::verdict_t verdict
);
  import x86cc_pkg::*;

  localparam int LEN_W = CNT_W + 9;
  localparam int HIT_W = CNT_W + 4;
  localparam int EXE_W = CNT_W + 7;

  logic [LEN_W-1:0] calls_scaled;
  logic [HIT_W-1:0] hits_scaled;
  logic [EXE_W-1:0] exe_scaled;
  logic [CMP_W-1:0] calls_ext;

  // Each product is a counter or counter sum times a constant; no overflow.
  assign calls_scaled = LEN_W'(counts.calls) * LEN_W'(LEN_RATIO);
  assign hits_scaled  = (HIT_W'(counts.exe) + HIT_W'(counts.obj)) * HIT_W'(HIT_RATIO);
  assign exe_scaled   = EXE_W'(counts.exe) * EXE_W'(EXE_RATIO);
  assign calls_ext    = CMP_W'(counts.calls);

  assign verdict.is_exe = (calls_scaled >= LEN_W'(counts.len)) &&
                          (hits_scaled >= HIT_W'(counts.calls)) &&
                          (exe_scaled >= EXE_W'(counts.calls));

  assign verdict.call_count = (calls_ext > CMP_W'(COUNT_OUT_MAX)) ?
                              CALL_CNT_W'(COUNT_OUT_MAX) :
                              CALL_CNT_W'(calls_ext);

endmodule

`default_nettype wire

/* src/x86_call_chunk_classifier_core.sv */
// ----------------------------------------------------------------------------
// x86_call_chunk_classifier_core
// Classifies a byte chunk as x86 code or plain data by counting E8 calls.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one chunk byte per transaction; last_byte marks the final
//   byte. verdict_out carries exactly one transaction per chunk: is_exe and
//   the number of counted call opcodes. Bytes with last_byte low produce
//   nothing on verdict_out.
//   Throughput is one byte per cycle while byte_in is ready. A byte passes
//   an input register, then the counter and window update; a last byte
//   snapshots the counters into the snapshot register, and the ratio
//   compares feed the output register, which drives verdict_out.
//   When verdict_out stalls, bytes that are not the last of their chunk keep
//   flowing, since they only update the counters; a last byte waits in the
//   input register until the snapshot stage frees up, and byte_in drops
//   ready only while such a byte is waiting.
//   Reset (rst, synchronous) empties every stage and clears the counters and
//   the five-byte window, so the first byte after reset starts a new chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_call_chunk_classifier_core (
  input  wire logic   clk,
  input  wire logic   rst,
  x86cc_in_if.sink    byte_in,
  x86cc_out_if.source verdict_out
);
  import x86cc_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Chunk state.
  logic [7:0] recent_bytes [WIN_DEPTH];
  cnt_t       byte_count;
  cnt_t       call_total;
  cnt_t       exe_hits;
  cnt_t       obj_hits;
  cnt_t       byte_count_next;
  cnt_t       call_total_next;
  cnt_t       exe_hits_next;
  cnt_t       obj_hits_next;

  // Snapshot register and output register.
  logic       s2_valid;
  counts_t    s2_counts;
  verdict_t   verdict;
  logic       out_valid;
  verdict_t   out_data;

  logic       out_en;
  logic       s2_en;
  logic       s1_go;
  logic       s1_en;
  logic       candidate;

  // Each stage moves on when the stage after it is empty or draining.
  // A non-final byte leaves nothing for the snapshot stage, so it never waits.
  assign out_en = !out_valid || verdict_out.ready;
  assign s2_en  = !s2_valid || out_en;
  assign s1_go  = s1_valid && (!s1_last || s2_en);
  assign s1_en  = !s1_valid || s1_go;

  assign byte_in.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && byte_in.valid) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.last_byte;
    end
  end

  // The oldest window byte opens a candidate that completes with this byte;
  // the window holds valid history only after five bytes of the chunk.
  assign candidate = (byte_count >= CNT_W'(WIN_DEPTH)) &&
                     (recent_bytes[0] == CALL_OPCODE);

  always_comb begin
    call_total_next = call_total;
    exe_hits_next   = exe_hits;
    obj_hits_next   = obj_hits;
    if (candidate) begin
      call_total_next = sat_inc(call_total);
      if ((recent_bytes[WIN_DEPTH-1] == BYTE_ONES) && (s1_byte != BYTE_ONES)) begin
        exe_hits_next = sat_inc(exe_hits);
      end
      if ((recent_bytes[WIN_DEPTH-1] == BYTE_ZERO) && (s1_byte != BYTE_ZERO)) begin
        obj_hits_next = sat_inc(obj_hits);
      end
    end
    byte_count_next = sat_inc(byte_count);
  end

  // Counters and window clear once the last byte has been snapshotted.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      call_total <= '0;
      exe_hits   <= '0;
      obj_hits   <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        recent_bytes[i] <= '0;
      end
    end else if (s1_go) begin
      if (s1_last) begin
        byte_count <= '0;
        call_total <= '0;
        exe_hits   <= '0;
        obj_hits   <= '0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
          recent_bytes[i] <= '0;
        end
      end else begin
        byte_count <= byte_count_next;
        call_total <= call_total_next;
        exe_hits   <= exe_hits_next;
        obj_hits   <= obj_hits_next;
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          recent_bytes[i] <= recent_bytes[i+1];
        end
        recent_bytes[WIN_DEPTH-1] <= s1_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_go && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_go && s1_last) begin
      s2_counts.len   <= byte_count_next;
      s2_counts.calls <= call_total_next;
      s2_counts.exe   <= exe_hits_next;
      s2_counts.obj   <= obj_hits_next;
    end
  end

  x86cc_verdict u_verdict (
    .counts  (s2_counts),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      out_data <= verdict;
    end
  end

  assign verdict_out.valid      = out_valid;
  assign verdict_out.is_exe     = out_data.is_exe;
  assign verdict_out.call_count = out_data.call_count;

endmodule

`default_nettype wire
